### rtl/core/rbb_pkg.sv
// Shared types, constants and arithmetic helpers of the rotated box bounds block.
`default_nettype none
package rbb_pkg;

	localparam int LANES         = 3;
	localparam int CORDIC_STAGES = 16;

	// Angle units are Q10.6 degrees.
	localparam int TURN_UNITS         = 23040;
	localparam int HALF_TURN_UNITS    = 11520;
	localparam int QUARTER_TURN_UNITS = 5760;

	localparam int XY_W = 34;
	localparam int Z_W  = 25;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [XY_W-1:0] ONE_Q30         = 34'sd1073741824;

	typedef logic signed [XY_W-1:0] cq_t;
	typedef logic signed [Z_W-1:0]  cz_t;
	typedef logic signed [15:0]     ang_t;
	typedef logic signed [31:0]     q30_t;
	typedef logic signed [31:0]     coord_t;
	typedef logic [30:0]            size_t;

	// Center and size of one box, carried alongside the angle work.
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		size_t  wx;
		size_t  wy;
		size_t  wz;
	} box_t;

	// Arctangent of 2^-i in degrees, scaled by 2^16.
	function automatic cz_t atan_deg(input int i);
		cz_t r;
		unique case (i)
			0:       r = 25'sd2949120;
			1:       r = 25'sd1740967;
			2:       r = 25'sd919879;
			3:       r = 25'sd466945;
			4:       r = 25'sd234379;
			5:       r = 25'sd117304;
			6:       r = 25'sd58666;
			7:       r = 25'sd29335;
			8:       r = 25'sd14668;
			9:       r = 25'sd7334;
			10:      r = 25'sd3667;
			11:      r = 25'sd1833;
			12:      r = 25'sd917;
			13:      r = 25'sd458;
			14:      r = 25'sd229;
			default: r = 25'sd115;
		endcase
		return r;
	endfunction

	// Q2.30 product, rounded half up by a floor shift.
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

	// Clamp a CORDIC output to plus or minus one.
	function automatic q30_t clamp_q30(input cq_t v);
		cq_t r;
		if (v > ONE_Q30) begin
			r = ONE_Q30;
		end else if (v < -ONE_Q30) begin
			r = -ONE_Q30;
		end else begin
			r = v;
		end
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/rbb_cordic.sv
// Angle folding and pipelined CORDIC for the three rotation angles.
`default_nettype none
module rbb_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire rbb_pkg::ang_t      ang   [rbb_pkg::LANES],
	input  wire rbb_pkg::box_t      box_in,
	output logic                    out_vld,
	output rbb_pkg::q30_t           sin_o [rbb_pkg::LANES],
	output rbb_pkg::q30_t           cos_o [rbb_pkg::LANES],
	output rbb_pkg::box_t           box_out
);
	import rbb_pkg::*;

	logic [CORDIC_STAGES:0] v_s;
	cq_t  x_s   [CORDIC_STAGES+1][LANES];
	cq_t  y_s   [CORDIC_STAGES+1][LANES];
	cz_t  z_s   [CORDIC_STAGES+1][LANES];
	logic neg_s [CORDIC_STAGES+1][LANES];
	box_t box_s [CORDIC_STAGES+1];

	logic  vld_sc_q;
	q30_t  sin_sc_q [LANES];
	q30_t  cos_sc_q [LANES];
	box_t  box_sc_q;

	cz_t   z0   [LANES];
	logic  neg0 [LANES];

	// Reduce each angle into half a turn either side, then fold into a quarter turn.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic signed [16:0] v;
			v = 17'(ang[l]);
			if (v >= 17'sd11520) begin
				v = v - 17'(TURN_UNITS);
			end else if (v < -17'sd11520) begin
				v = v + 17'(TURN_UNITS);
			end
			neg0[l] = 1'b0;
			if (v > 17'(QUARTER_TURN_UNITS)) begin
				v = 17'(HALF_TURN_UNITS) - v;
				neg0[l] = 1'b1;
			end else if (v < -17'sd5760) begin
				v = -17'(HALF_TURN_UNITS) - v;
				neg0[l] = 1'b1;
			end
			z0[l] = Z_W'(v) <<< 10;
		end
	end

	// Entry stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s[0] <= box_in;
			for (int l = 0; l < LANES; l++) begin
				x_s[0][l]   <= CORDIC_GAIN_Q30;
				y_s[0][l]   <= '0;
				z_s[0][l]   <= z0[l];
				neg_s[0][l] <= neg0[l];
			end
		end
	end

	// One rotation step per stage.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				box_s[i+1] <= box_s[i];
				for (int l = 0; l < LANES; l++) begin
					neg_s[i+1][l] <= neg_s[i][l];
					if (!z_s[i][l][Z_W-1]) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - atan_deg(i);
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + atan_deg(i);
					end
				end
			end
		end
	end

	// Clamp and apply the fold sign to the cosine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc_q <= 1'b0;
		end else if (en) begin
			vld_sc_q <= v_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_sc_q <= box_s[CORDIC_STAGES];
			for (int l = 0; l < LANES; l++) begin
				sin_sc_q[l] <= clamp_q30(y_s[CORDIC_STAGES][l]);
				cos_sc_q[l] <= neg_s[CORDIC_STAGES][l] ? -clamp_q30(x_s[CORDIC_STAGES][l])
				                                       : clamp_q30(x_s[CORDIC_STAGES][l]);
			end
		end
	end

	assign out_vld = vld_sc_q;
	assign sin_o   = sin_sc_q;
	assign cos_o   = cos_sc_q;
	assign box_out = box_sc_q;

endmodule
`default_nettype wire

### rtl/core/rbb_bounds.sv
// Rotation matrix, extents and saturated bounds, as a six stage pipeline.
`default_nettype none
module rbb_bounds (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire rbb_pkg::q30_t      sin_i [rbb_pkg::LANES],
	input  wire rbb_pkg::q30_t      cos_i [rbb_pkg::LANES],
	input  wire rbb_pkg::box_t      box_in,
	output logic                    out_vld,
	output rbb_pkg::coord_t         min_x,
	output rbb_pkg::coord_t         max_x,
	output rbb_pkg::coord_t         min_y,
	output rbb_pkg::coord_t         max_y,
	output rbb_pkg::coord_t         min_z,
	output rbb_pkg::coord_t         max_z
);
	import rbb_pkg::*;

	logic [5:0] v_s;

	// Stage 1: pairwise products.
	q30_t cycz_s1, sxsy_s1, cxsy_s1, cysz_s1, cxsz_s1, sxsz_s1, cxcz_s1, sxcz_s1;
	q30_t sxcy_s1, cxcy_s1, sy_s1, cz_s1, sz_s1;
	box_t box_s1;
	// Stage 2: triple products.
	q30_t t1_s2, t2_s2, t3_s2, t4_s2;
	q30_t cycz_s2, cxsz_s2, sxsz_s2, cysz_s2, cxcz_s2, sxcz_s2, sy_s2, sxcy_s2, cxcy_s2;
	box_t box_s2;
	// Stage 3: absolute matrix entries.
	logic [31:0] m_s3 [9];
	box_t box_s3;
	// Stage 4: weighted sizes.
	logic [62:0] p_s4 [9];
	box_t box_s4;
	// Stage 5: extents.
	logic [33:0] ex_s5, ey_s5, ez_s5;
	box_t box_s5;
	// Stage 6: output registers.
	coord_t min_x_s6, max_x_s6, min_y_s6, max_y_s6, min_z_s6, max_z_s6;

	function automatic logic [31:0] abs33(input logic signed [32:0] v);
		logic signed [32:0] a;
		a = v[32] ? -v : v;
		return a[31:0];
	endfunction

	function automatic coord_t sat36(input logic signed [35:0] v);
		coord_t r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [33:0] ext_of(input logic [62:0] a, input logic [62:0] b,
	                                       input logic [62:0] c);
		logic [64:0] s;
		s = 65'(a) + 65'(b) + 65'(c) + 65'h40000000;
		return s[64:31];
	endfunction

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycz_s1 <= mul_q30(cos_i[1], cos_i[2]);
			sxsy_s1 <= mul_q30(sin_i[0], sin_i[1]);
			cxsy_s1 <= mul_q30(cos_i[0], sin_i[1]);
			cysz_s1 <= mul_q30(cos_i[1], sin_i[2]);
			cxsz_s1 <= mul_q30(cos_i[0], sin_i[2]);
			sxsz_s1 <= mul_q30(sin_i[0], sin_i[2]);
			cxcz_s1 <= mul_q30(cos_i[0], cos_i[2]);
			sxcz_s1 <= mul_q30(sin_i[0], cos_i[2]);
			sxcy_s1 <= mul_q30(sin_i[0], cos_i[1]);
			cxcy_s1 <= mul_q30(cos_i[0], cos_i[1]);
			sy_s1   <= sin_i[1];
			cz_s1   <= cos_i[2];
			sz_s1   <= sin_i[2];
			box_s1  <= box_in;

			t1_s2   <= mul_q30(sxsy_s1, cz_s1);
			t2_s2   <= mul_q30(cxsy_s1, cz_s1);
			t3_s2   <= mul_q30(sxsy_s1, sz_s1);
			t4_s2   <= mul_q30(cxsy_s1, sz_s1);
			cycz_s2 <= cycz_s1;
			cxsz_s2 <= cxsz_s1;
			sxsz_s2 <= sxsz_s1;
			cysz_s2 <= cysz_s1;
			cxcz_s2 <= cxcz_s1;
			sxcz_s2 <= sxcz_s1;
			sy_s2   <= sy_s1;
			sxcy_s2 <= sxcy_s1;
			cxcy_s2 <= cxcy_s1;
			box_s2  <= box_s1;

			m_s3[0] <= abs33(33'(cycz_s2));
			m_s3[1] <= abs33(33'(t1_s2) - 33'(cxsz_s2));
			m_s3[2] <= abs33(33'(t2_s2) + 33'(sxsz_s2));
			m_s3[3] <= abs33(33'(cysz_s2));
			m_s3[4] <= abs33(33'(t3_s2) + 33'(cxcz_s2));
			m_s3[5] <= abs33(33'(t4_s2) - 33'(sxcz_s2));
			m_s3[6] <= abs33(33'(sy_s2));
			m_s3[7] <= abs33(33'(sxcy_s2));
			m_s3[8] <= abs33(33'(cxcy_s2));
			box_s3  <= box_s2;

			// Each row of the matrix weights the x, y and z sizes.
			for (int r = 0; r < 3; r++) begin
				p_s4[3*r]   <= 63'(m_s3[3*r])   * 63'(box_s3.wx);
				p_s4[3*r+1] <= 63'(m_s3[3*r+1]) * 63'(box_s3.wy);
				p_s4[3*r+2] <= 63'(m_s3[3*r+2]) * 63'(box_s3.wz);
			end
			box_s4 <= box_s3;

			// The extra shift by one halves the full size.
			ex_s5  <= ext_of(p_s4[0], p_s4[1], p_s4[2]);
			ey_s5  <= ext_of(p_s4[3], p_s4[4], p_s4[5]);
			ez_s5  <= ext_of(p_s4[6], p_s4[7], p_s4[8]);
			box_s5 <= box_s4;

			min_x_s6 <= sat36(36'(box_s5.cx) - $signed({2'b00, ex_s5}));
			max_x_s6 <= sat36(36'(box_s5.cx) + $signed({2'b00, ex_s5}));
			min_y_s6 <= sat36(36'(box_s5.cy) - $signed({2'b00, ey_s5}));
			max_y_s6 <= sat36(36'(box_s5.cy) + $signed({2'b00, ey_s5}));
			min_z_s6 <= sat36(36'(box_s5.cz) - $signed({2'b00, ez_s5}));
			max_z_s6 <= sat36(36'(box_s5.cz) + $signed({2'b00, ez_s5}));
		end
	end

	assign out_vld = v_s[5];
	assign min_x   = min_x_s6;
	assign max_x   = max_x_s6;
	assign min_y   = min_y_s6;
	assign max_y   = max_y_s6;
	assign min_z   = min_z_s6;
	assign max_z   = max_z_s6;

endmodule
`default_nettype wire

### rtl/core/rotated_box_bounds_top.sv
// Top level of the rotated box bounds pipeline.
`default_nettype none
// Accepts one box per cycle while the output is not stalled and returns its
// axis-aligned bounds: one fold stage, sixteen CORDIC rotation stages and
// a clamp stage run the three angles side by side, then six stages form the
// rotation matrix products, the weighted extents and the saturated corners.
// When the output is not taken the whole pipeline holds, so in_ready follows
// out_ready whenever a result is waiting at the output.
module rotated_box_bounds_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rbb_pkg::coord_t center_x,
	input  wire rbb_pkg::coord_t center_y,
	input  wire rbb_pkg::coord_t center_z,
	input  wire rbb_pkg::size_t  size_x,
	input  wire rbb_pkg::size_t  size_y,
	input  wire rbb_pkg::size_t  size_z,
	input  wire rbb_pkg::ang_t   angle_x,
	input  wire rbb_pkg::ang_t   angle_y,
	input  wire rbb_pkg::ang_t   angle_z,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rbb_pkg::coord_t      min_x,
	output rbb_pkg::coord_t      max_x,
	output rbb_pkg::coord_t      min_y,
	output rbb_pkg::coord_t      max_y,
	output rbb_pkg::coord_t      min_z,
	output rbb_pkg::coord_t      max_z
);
	import rbb_pkg::*;

	logic en;
	ang_t ang [LANES];
	box_t box_in;
	logic cd_vld;
	q30_t sin_w [LANES];
	q30_t cos_w [LANES];
	box_t box_cd;

	// The pipeline moves whenever the output stage is empty or being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign ang[0] = angle_x;
	assign ang[1] = angle_y;
	assign ang[2] = angle_z;
	assign box_in = '{cx: center_x, cy: center_y, cz: center_z,
	                  wx: size_x, wy: size_y, wz: size_z};

	rbb_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.ang     (ang),
		.box_in  (box_in),
		.out_vld (cd_vld),
		.sin_o   (sin_w),
		.cos_o   (cos_w),
		.box_out (box_cd)
	);

	rbb_bounds u_bounds (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cd_vld),
		.sin_i   (sin_w),
		.cos_i   (cos_w),
		.box_in  (box_cd),
		.out_vld (out_valid),
		.min_x   (min_x),
		.max_x   (max_x),
		.min_y   (min_y),
		.max_y   (max_y),
		.min_z   (min_z),
		.max_z   (max_z)
	);

endmodule
`default_nettype wire

### rtl/core/rbb_checker.sv
// Port-level checks of the rotated box bounds block and their binding.
`default_nettype none
module rbb_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire rbb_pkg::coord_t center_x,
	input wire rbb_pkg::coord_t center_y,
	input wire rbb_pkg::coord_t center_z,
	input wire rbb_pkg::size_t  size_x,
	input wire rbb_pkg::size_t  size_y,
	input wire rbb_pkg::size_t  size_z,
	input wire rbb_pkg::ang_t   angle_x,
	input wire rbb_pkg::ang_t   angle_y,
	input wire rbb_pkg::ang_t   angle_z,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire rbb_pkg::coord_t min_x,
	input wire rbb_pkg::coord_t max_x,
	input wire rbb_pkg::coord_t min_y,
	input wire rbb_pkg::coord_t max_y,
	input wire rbb_pkg::coord_t min_z,
	input wire rbb_pkg::coord_t max_z
);
	// A waiting input item stays offered with the same box.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable({center_x, center_y, center_z,
			size_x, size_y, size_z, angle_x, angle_y, angle_z}))
		else $error("input item changed while waiting");

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A waiting result keeps its value, as checked on min_x and max_z.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(min_x) && $stable(max_z))
		else $error("result changed while stalled");

	// A stalled output freezes the pipeline, so no item enters.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");

	// Extents are never negative, so no lower bound lies above its upper bound.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
		else $error("lower bound above upper bound");

endmodule

bind rotated_box_bounds_top rbb_checker u_rbb_checker (.*);
`default_nettype wire

### bench/rbb_checker.sv
// Checker that predicts and compares the bounds of every box passing through the block.
module rbb_scoreboard (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  rbb_pkg::coord_t center_x,
	input  rbb_pkg::coord_t center_y,
	input  rbb_pkg::coord_t center_z,
	input  rbb_pkg::size_t  size_x,
	input  rbb_pkg::size_t  size_y,
	input  rbb_pkg::size_t  size_z,
	input  rbb_pkg::ang_t   angle_x,
	input  rbb_pkg::ang_t   angle_y,
	input  rbb_pkg::ang_t   angle_z,
	input  logic            out_valid,
	input  logic            out_ready,
	input  rbb_pkg::coord_t min_x,
	input  rbb_pkg::coord_t max_x,
	input  rbb_pkg::coord_t min_y,
	input  rbb_pkg::coord_t max_y,
	input  rbb_pkg::coord_t min_z,
	input  rbb_pkg::coord_t max_z,
	output int              errors,
	output int              pending,
	output int              boxes_checked
);
	import rbb_pkg::*;

	typedef struct {
		coord_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	} bounds_t;

	localparam longint ATAN_Q16 [16] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	bounds_t expected_bounds[$];

	// Rounded Q2.30 product with a floor shift.
	function automatic longint qmul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	// Sine and cosine of a Q10.6 degree angle by a folded CORDIC.
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint r, x, y, z, nx;
		bit flip;
		r = ang % TURN_UNITS;
		flip = 0;
		x = 652032874;
		y = 0;
		if (r < 0) r += TURN_UNITS;
		if (r >= HALF_TURN_UNITS) r -= TURN_UNITS;
		if (r > QUARTER_TURN_UNITS) begin
			r = HALF_TURN_UNITS - r;
			flip = 1;
		end else if (r < -QUARTER_TURN_UNITS) begin
			r = -HALF_TURN_UNITS - r;
			flip = 1;
		end
		z = r * 1024;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q16[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q16[i];
			end
			x = nx;
		end
		if (x > 1073741824) x = 1073741824;
		if (x < -1073741824) x = -1073741824;
		if (y > 1073741824) y = 1073741824;
		if (y < -1073741824) y = -1073741824;
		c = flip ? -x : x;
		s = y;
	endfunction

	// Half extent: absolute matrix row weighted by the full sizes, rounded.
	function automatic longint half_extent(input longint m0, m1, m2, input longint w0, w1, w2);
		bit [63:0] acc;
		acc = 64'(m0 < 0 ? -m0 : m0) * 64'(w0) + 64'(m1 < 0 ? -m1 : m1) * 64'(w1)
			+ 64'(m2 < 0 ? -m2 : m2) * 64'(w2);
		return longint'((acc + 64'd1073741824) >> 31);
	endfunction

	function automatic coord_t sat32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic bounds_t predict_bounds();
		longint sx, cx, sy, cy, sz, cz, ex, ey, ez, px, py, pz, wx, wy, wz;
		bounds_t b;
		px = center_x; py = center_y; pz = center_z;
		wx = size_x; wy = size_y; wz = size_z;
		sin_cos(angle_x, sx, cx);
		sin_cos(angle_y, sy, cy);
		sin_cos(angle_z, sz, cz);
		ex = half_extent(qmul(cy, cz), qmul(qmul(sx, sy), cz) - qmul(cx, sz),
			qmul(qmul(cx, sy), cz) + qmul(sx, sz), wx, wy, wz);
		ey = half_extent(qmul(cy, sz), qmul(qmul(sx, sy), sz) + qmul(cx, cz),
			qmul(qmul(cx, sy), sz) - qmul(sx, cz), wx, wy, wz);
		ez = half_extent(sy, qmul(sx, cy), qmul(cx, cy), wx, wy, wz);
		b.lo_x = sat32(px - ex); b.hi_x = sat32(px + ex);
		b.lo_y = sat32(py - ey); b.hi_y = sat32(py + ey);
		b.lo_z = sat32(pz - ez); b.hi_z = sat32(pz + ez);
		return b;
	endfunction

	// Queue a prediction per accepted box and compare each delivered item.
	always @(posedge clk) begin
		bounds_t e;
		if (arst_n && in_valid && in_ready)
			expected_bounds.push_back(predict_bounds());
		if (arst_n && out_valid && out_ready) begin
			if (expected_bounds.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result item at %0t", $realtime);
			end else begin
				e = expected_bounds.pop_front();
				boxes_checked++;
				if ({min_x, max_x, min_y, max_y, min_z, max_z} !==
					{e.lo_x, e.hi_x, e.lo_y, e.hi_y, e.lo_z, e.hi_z}) begin
					errors++;
					if (errors <= 10)
						$display({"Mismatch at %0t: exp x[%0d,%0d] y[%0d,%0d] z[%0d,%0d]",
							" got x[%0d,%0d] y[%0d,%0d] z[%0d,%0d]"},
							$realtime, e.lo_x, e.hi_x, e.lo_y, e.hi_y, e.lo_z, e.hi_z,
							min_x, max_x, min_y, max_y, min_z, max_z);
				end
			end
		end
		pending = expected_bounds.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		boxes_checked = 0;
	end
endmodule

### bench/tb_top.sv
// Testbench top: drives boxes and result stalls into the bounds block and reports the verdict.
module tb_top;
	import rbb_pkg::*;

	logic   clk = 0, arst_n = 0, in_valid = 0, out_ready = 0, in_ready, out_valid;
	coord_t center_x = 0, center_y = 0, center_z = 0;
	size_t  size_x = 0, size_y = 0, size_z = 0;
	ang_t   angle_x = 0, angle_y = 0, angle_z = 0;
	coord_t min_x, max_x, min_y, max_y, min_z, max_z;
	logic   box_taken = 0;
	logic   quiet = 0;
	int     errors, pending, boxes_checked;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	rotated_box_bounds_top dut (.*);
	rbb_scoreboard chk (.*);

	// Records whether a box was accepted at the last rising edge.
	always @(posedge clk) box_taken <= in_valid && in_ready;

	// Result side: random stall bursts, none once the run goes quiet.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 17);
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	task automatic send_box(input coord_t px, py, pz, input size_t wx, wy, wz,
		input ang_t ax, ay, az);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1;
		center_x <= px; center_y <= py; center_z <= pz;
		size_x <= wx; size_y <= wy; size_z <= wz;
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		do @(negedge clk); while (!box_taken);
	endtask

	function automatic size_t rand_size();
		case ($urandom_range(0, 3))
			0: return size_t'($urandom);
			1: return size_t'($urandom_range(0, 32'h00ff_ffff));
			default: return size_t'($urandom_range(0, 32'h000f_ffff));
		endcase
	endfunction

	initial begin
		ang_t dir_angles[12];
		dir_angles = '{0, 5760, -5760, 11520, -11520, 17280, 23040, -23040,
			32767, -32768, 2880, -1};
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: zero size, extreme fields, quarter and half turns, saturation.
		send_box(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_box(32'sh7fffffff, 32'sh80000000, 12345, 0, 0, 0, 1000, -1000, 32767);
		send_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, 0, 0);
		send_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 2880, 2880, 2880);
		foreach (dir_angles[i])
			send_box(i * 65536, -i * 65536, 0, 31'h30000, 31'h10000, 31'h20000,
				dir_angles[i], dir_angles[(i + 3) % 12], dir_angles[(i + 7) % 12]);
		send_box(0, 0, 0, 31'h7fffffff, 0, 0, -32768, 32767, -32768);
		send_box(0, 0, 0, 0, 31'h7fffffff, 0, 5760, 5760, 5760);
		send_box(0, 0, 0, 0, 0, 31'h7fffffff, -5760, 11520, 17280);
		in_valid <= 0;
		// Let the pipeline drain completely before the random part.
		do @(negedge clk); while (pending != 0);
		for (int n = 0; n < 700; n++) begin
			if (n == 600) quiet = 1;
			send_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				rand_size(), rand_size(), rand_size(),
				ang_t'($urandom), ang_t'($urandom), ang_t'($urandom));
		end
		in_valid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (40) @(negedge clk);
		$display("Checked %0d boxes: directed extremes, quarter and half turns, saturation,",
			boxes_checked);
		$display("then random boxes with stall bursts on both channels and one full drain.");
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end
endmodule
